[sv/frws_pkg.sv]
package frws_pkg;

    // fixed field widths
    localparam int TIME_W   = 24;
    localparam int RATE_W   = 28;
    localparam int TIMER_W  = 25;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // parameter defaults
    localparam int WINDOW_SIZE_DEF = 128;
    localparam int PERCENT_DIV     = 100;

    // rate = 1e6 * 256 / time, saturating on a zero time
    localparam logic [RATE_W-1:0] RATE_NUM = 28'd256000000;
    localparam logic [RATE_W-1:0] RATE_MAX = 28'hFFF_FFFF;

    localparam logic [TIME_W-1:0] INTERVAL_RESET = 24'd500000;

    // register index, byte address 4 * index
    localparam logic REG_INTERVAL = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDIV,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_KSUM,
        ST_MDIV,
        ST_LDIV,
        ST_HDIV,
        ST_OUT
    } state_t;

endpackage

[sv/frws_div.sv]
module frws_div #(
    parameter int NUM_W = frws_pkg::RATE_W + $clog2(frws_pkg::WINDOW_SIZE_DEF),
    parameter int DEN_W = frws_pkg::TIME_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             borrow;

    // one restoring step per cycle, msb first
    assign trial  = {rem_reg, num_reg[NUM_W-1]};
    assign diff   = trial - {1'b0, den_reg};
    assign borrow = diff[DEN_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], ~borrow};
            rem_reg <= borrow ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

[sv/frame_rate_window_stats_top.sv]
// Frame rate statistics. Each request carries one frame time in microseconds and
// returns one result: the rate of that frame (1e6 * 256 / time, 8 fraction bits,
// a zero time saturates to all ones) plus the held window mean, the mean of the
// k smallest and the mean of the k largest rates, k = max(1, WINDOW_SIZE / 100).
// Rates go into a ring window of WINDOW_SIZE entries in a memory with one write
// and one read port; slots not yet written count as zero rates. Frame times add
// up in an interval timer; once it reaches report_interval_us (APB register 0,
// reset 500000) the statistics are recomputed over the whole window, the timer
// clears, and the result carries report_fresh. All divisions truncate and share
// one radix-2 divider that takes NUM_W = 28 + clog2(WINDOW_SIZE) steps per
// quotient (35 at the default window of 128). A plain request runs one rate
// division (none for a zero frame time), writes the rate into the window and
// loads the output; a reporting one adds a scan of every window slot, a pass
// that sums the k smallest and k largest rates, and three more divisions.
// One request is in flight at a time: s_ready is high only while idle, and a
// finished result waits in the output register while the next request is
// taken. No clearing pass is needed after reset.
module frame_rate_window_stats_top #(
    parameter int WINDOW_SIZE = frws_pkg::WINDOW_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // apb register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [frws_pkg::PADDR_W-1:0]  paddr,
    input  logic [frws_pkg::PDATA_W-1:0]  pwdata,
    output logic [frws_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,

    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [frws_pkg::TIME_W-1:0]   s_frame_time_us,

    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [frws_pkg::RATE_W-1:0]   m_current_rate,
    output logic [frws_pkg::RATE_W-1:0]   m_mean_rate,
    output logic [frws_pkg::RATE_W-1:0]   m_low_rate,
    output logic [frws_pkg::RATE_W-1:0]   m_high_rate,
    output logic                          m_report_fresh
);

    import frws_pkg::*;

    localparam int AW     = $clog2(WINDOW_SIZE);
    localparam int KEEP   = (WINDOW_SIZE / PERCENT_DIV < 1) ? 1 : WINDOW_SIZE / PERCENT_DIV;
    localparam int KCW    = (KEEP > 1) ? $clog2(KEEP) : 1;
    localparam int SUM_W  = RATE_W + AW;
    localparam int KSUM_W = RATE_W + $clog2(KEEP + 1);
    localparam int NUM_W  = SUM_W;

    // state
    state_t                state_reg, state_next;

    // configuration
    logic [TIME_W-1:0]     interval_reg;
    logic                  cfg_wr;

    // window bookkeeping
    logic [RATE_W-1:0]     rate_mem [WINDOW_SIZE];
    logic [AW-1:0]         slot_reg;
    logic                  wrapped_reg;
    logic [TIMER_W-1:0]    timer_reg;
    logic [TIMER_W-1:0]    timer_sum;
    logic                  report_due;

    // per request
    logic [TIME_W-1:0]     time_reg;
    logic [RATE_W-1:0]     rate_reg;
    logic                  fresh_reg;

    // scan
    logic [AW-1:0]         scan_idx_reg;
    logic                  scan_last;
    logic [RATE_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic                  rd_live_reg;
    logic [RATE_W-1:0]     scan_val;
    logic [SUM_W-1:0]      sum_reg;
    logic [RATE_W-1:0]     low_reg  [KEEP];
    logic [RATE_W-1:0]     high_reg [KEEP];
    logic [RATE_W-1:0]     low_ins  [KEEP];
    logic [RATE_W-1:0]     high_ins [KEEP];
    logic [KCW-1:0]        kcnt_reg;
    logic                  kcnt_last;
    logic [KSUM_W-1:0]     low_sum_reg;
    logic [KSUM_W-1:0]     high_sum_reg;

    // held statistics
    logic [RATE_W-1:0]     held_mean_reg;
    logic [RATE_W-1:0]     held_low_reg;
    logic [RATE_W-1:0]     held_high_reg;

    // output register
    logic                  m_valid_reg;
    logic [RATE_W-1:0]     out_rate_reg;
    logic [RATE_W-1:0]     out_mean_reg;
    logic [RATE_W-1:0]     out_low_reg;
    logic [RATE_W-1:0]     out_high_reg;
    logic                  out_fresh_reg;
    logic                  out_load;

    // shared divider
    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    logic [TIME_W-1:0]     div_den;
    logic                  div_done;
    logic [NUM_W-1:0]      div_quot;

    frws_div #(
        .NUM_W (NUM_W),
        .DEN_W (TIME_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // ---------------------------------------------------------------
    // register port: register index is paddr[2]
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_INTERVAL);
    assign prdata = (paddr[2] == REG_INTERVAL)
                  ? {{(PDATA_W - TIME_W){1'b0}}, interval_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_wr) begin
            interval_reg <= pwdata[TIME_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // helpers
    // ---------------------------------------------------------------
    assign timer_sum  = timer_reg + TIMER_W'(time_reg);
    assign report_due = timer_sum >= TIMER_W'(interval_reg);
    assign scan_last  = scan_idx_reg == AW'(WINDOW_SIZE - 1);
    assign kcnt_last  = kcnt_reg == KCW'(KEEP - 1);
    assign scan_val   = rd_live_reg ? rd_data_reg : '0;
    assign out_load   = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // sorted insertion: low list ascending keeps the k smallest,
    // high list descending keeps the k largest
    always_comb begin
        for (int j = 0; j < KEEP; j++) begin
            if (low_reg[j] <= scan_val) begin
                low_ins[j] = low_reg[j];
            end else if (j == 0) begin
                low_ins[j] = scan_val;
            end else if (low_reg[(j == 0) ? 0 : j - 1] <= scan_val) begin
                low_ins[j] = scan_val;
            end else begin
                low_ins[j] = low_reg[(j == 0) ? 0 : j - 1];
            end

            if (high_reg[j] >= scan_val) begin
                high_ins[j] = high_reg[j];
            end else if (j == 0) begin
                high_ins[j] = scan_val;
            end else if (high_reg[(j == 0) ? 0 : j - 1] >= scan_val) begin
                high_ins[j] = scan_val;
            end else begin
                high_ins[j] = high_reg[(j == 0) ? 0 : j - 1];
            end
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_num    = NUM_W'(RATE_NUM);
        div_den    = s_frame_time_us;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_frame_time_us == '0) begin
                        state_next = ST_WRITE;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_RDIV;
                    end
                end
            end
            ST_RDIV: begin
                if (div_done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = report_due ? ST_SCAN : ST_OUT;
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_KSUM;
            end
            ST_KSUM: begin
                div_num = sum_reg;
                div_den = TIME_W'(WINDOW_SIZE);
                if (kcnt_last) begin
                    div_start  = 1'b1;
                    state_next = ST_MDIV;
                end
            end
            ST_MDIV: begin
                div_num = NUM_W'(low_sum_reg);
                div_den = TIME_W'(KEEP);
                if (div_done) begin
                    div_start  = 1'b1;
                    state_next = ST_LDIV;
                end
            end
            ST_LDIV: begin
                div_num = NUM_W'(high_sum_reg);
                div_den = TIME_W'(KEEP);
                if (div_done) begin
                    div_start  = 1'b1;
                    state_next = ST_HDIV;
                end
            end
            ST_HDIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // ---------------------------------------------------------------
    // window memory, one write and one registered read port
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            rate_mem[slot_reg] <= rate_reg;
        end
        rd_data_reg <= rate_mem[scan_idx_reg];
    end

    // ---------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= '0;
            wrapped_reg   <= 1'b0;
            timer_reg     <= '0;
            held_mean_reg <= '0;
            held_low_reg  <= '0;
            held_high_reg <= '0;
            rd_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            rd_valid_reg <= (state_reg == ST_SCAN);

            if (state_reg == ST_WRITE) begin
                // advance ring slot; slots past the fill point read as zero
                if (slot_reg == AW'(WINDOW_SIZE - 1)) begin
                    slot_reg    <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    slot_reg <= slot_reg + 1'b1;
                end
                timer_reg <= report_due ? '0 : timer_sum;
            end

            if (div_done) begin
                unique case (state_reg)
                    ST_MDIV: held_mean_reg <= div_quot[RATE_W-1:0];
                    ST_LDIV: held_low_reg  <= div_quot[RATE_W-1:0];
                    ST_HDIV: held_high_reg <= div_quot[RATE_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // datapath
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            time_reg <= s_frame_time_us;
            rate_reg <= RATE_MAX;
        end
        if (state_reg == ST_RDIV && div_done) begin
            rate_reg <= div_quot[RATE_W-1:0];
        end

        if (state_reg == ST_WRITE) begin
            // set up the scan
            fresh_reg    <= report_due;
            scan_idx_reg <= '0;
            sum_reg      <= '0;
            kcnt_reg     <= '0;
            low_sum_reg  <= '0;
            high_sum_reg <= '0;
            for (int j = 0; j < KEEP; j++) begin
                low_reg[j]  <= RATE_MAX;
                high_reg[j] <= '0;
            end
        end

        if (state_reg == ST_SCAN) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            rd_live_reg  <= wrapped_reg || (scan_idx_reg < slot_reg);
        end

        // read data lands in the cycle after its address
        if (rd_valid_reg) begin
            sum_reg <= sum_reg + SUM_W'(scan_val);
            for (int j = 0; j < KEEP; j++) begin
                low_reg[j]  <= low_ins[j];
                high_reg[j] <= high_ins[j];
            end
        end

        // pop both lists from the front to sum the extremes
        if (state_reg == ST_KSUM) begin
            low_sum_reg  <= low_sum_reg + KSUM_W'(low_reg[0]);
            high_sum_reg <= high_sum_reg + KSUM_W'(high_reg[0]);
            kcnt_reg     <= kcnt_reg + 1'b1;
            for (int j = 0; j < KEEP - 1; j++) begin
                low_reg[j]  <= low_reg[j + 1];
                high_reg[j] <= high_reg[j + 1];
            end
        end

        if (out_load) begin
            out_rate_reg  <= rate_reg;
            out_mean_reg  <= held_mean_reg;
            out_low_reg   <= held_low_reg;
            out_high_reg  <= held_high_reg;
            out_fresh_reg <= fresh_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_current_rate = out_rate_reg;
    assign m_mean_rate    = out_mean_reg;
    assign m_low_rate     = out_low_reg;
    assign m_high_rate    = out_high_reg;
    assign m_report_fresh = out_fresh_reg;

endmodule

[tb/sv/frws_checker.sv]
module frws_checker #(
    parameter int WINDOW_SIZE = frws_pkg::WINDOW_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [frws_pkg::PADDR_W-1:0]  paddr,
    input  logic [frws_pkg::PDATA_W-1:0]  pwdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [frws_pkg::TIME_W-1:0]   s_frame_time_us,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [frws_pkg::RATE_W-1:0]   m_current_rate,
    input  logic [frws_pkg::RATE_W-1:0]   m_mean_rate,
    input  logic [frws_pkg::RATE_W-1:0]   m_low_rate,
    input  logic [frws_pkg::RATE_W-1:0]   m_high_rate,
    input  logic                          m_report_fresh,
    output int                            fail_count,
    output int                            pending
);

    import frws_pkg::*;

    typedef struct packed {
        logic [RATE_W-1:0] cur_rate;
        logic [RATE_W-1:0] mean_rate;
        logic [RATE_W-1:0] low_rate;
        logic [RATE_W-1:0] high_rate;
        logic              fresh;
    } frame_stats_t;

    localparam int K_EXTREME = (WINDOW_SIZE / PERCENT_DIV < 1) ? 1 : WINDOW_SIZE / PERCENT_DIV;

    logic [RATE_W-1:0]  rate_ring [WINDOW_SIZE];
    int unsigned        ring_slot;
    logic [TIMER_W-1:0] elapsed_us;
    logic [TIME_W-1:0]  interval_us;
    logic [RATE_W-1:0]  mean_held;
    logic [RATE_W-1:0]  low_held;
    logic [RATE_W-1:0]  high_held;
    frame_stats_t       stats_due [$];

    // mean over the ring, then mean of the k smallest and k largest rates
    function automatic void recompute_stats();
        logic [RATE_W-1:0] ordered [WINDOW_SIZE];
        logic [RATE_W-1:0] v;
        longint unsigned   total;
        longint unsigned   low_sum;
        longint unsigned   high_sum;
        int                i;
        int                j;
        total = 0;
        for (i = 0; i < WINDOW_SIZE; i++) begin
            total += rate_ring[i];
            ordered[i] = rate_ring[i];
        end
        mean_held = RATE_W'(total / WINDOW_SIZE);
        for (i = 1; i < WINDOW_SIZE; i++) begin
            v = ordered[i];
            j = i;
            while (j > 0 && ordered[j-1] > v) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = v;
        end
        low_sum  = 0;
        high_sum = 0;
        for (i = 0; i < K_EXTREME; i++) begin
            low_sum  += ordered[i];
            high_sum += ordered[WINDOW_SIZE-1-i];
        end
        low_held  = RATE_W'(low_sum / K_EXTREME);
        high_held = RATE_W'(high_sum / K_EXTREME);
    endfunction

    function automatic frame_stats_t step_frame(input logic [TIME_W-1:0] t);
        frame_stats_t r;
        // zero frame time saturates the rate and adds nothing to the timer
        r.cur_rate = (t == '0) ? RATE_MAX : RATE_NUM / RATE_W'(t);
        rate_ring[ring_slot] = r.cur_rate;
        ring_slot = (ring_slot == WINDOW_SIZE - 1) ? 0 : ring_slot + 1;
        elapsed_us = elapsed_us + TIMER_W'(t);
        r.fresh = (elapsed_us >= TIMER_W'(interval_us));
        if (r.fresh) begin
            recompute_stats();
            elapsed_us = '0;
        end
        r.mean_rate = mean_held;
        r.low_rate  = low_held;
        r.high_rate = high_held;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [RATE_W-1:0] want,
                               input logic [RATE_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        frame_stats_t want;
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                rate_ring[i] = '0;
            end
            ring_slot   = 0;
            elapsed_us  = '0;
            interval_us = INTERVAL_RESET;
            mean_held   = '0;
            low_held    = '0;
            high_held   = '0;
            fail_count  = 0;
            stats_due.delete();
        end else begin
            if (psel && penable && pwrite && pready
                && (paddr >> 2) == PADDR_W'(REG_INTERVAL)) begin
                interval_us = pwdata[TIME_W-1:0];
            end
            if (s_valid && s_ready) begin
                want = step_frame(s_frame_time_us);
                stats_due.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (stats_due.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = stats_due.pop_front();
                    check_field("current_rate", want.cur_rate, m_current_rate);
                    check_field("mean_rate", want.mean_rate, m_mean_rate);
                    check_field("low_rate", want.low_rate, m_low_rate);
                    check_field("high_rate", want.high_rate, m_high_rate);
                    check_field("report_fresh", RATE_W'(want.fresh), RATE_W'(m_report_fresh));
                end
            end
        end
        pending = stats_due.size();
    end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    import frws_pkg::*;

    // run shape: a directed opener, then phases of random requests, each phase
    // under its own report interval written while the block is idle
    localparam int PHASES       = 13;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 2000;
    localparam int DRAIN_CYCLES = 400;
    // even if every one of the roughly 2000 requests reports, the run plus idling
    // stays well under this
    localparam int RUN_LIMIT    = 30_000_000;

    // register index 1 does not exist and a write there must change nothing
    localparam int                 SPARE_REG     = 1;
    localparam logic [PADDR_W-1:0] INTERVAL_ADDR = PADDR_W'(4 * REG_INTERVAL);
    localparam logic [PADDR_W-1:0] SPARE_ADDR    = PADDR_W'(4 * SPARE_REG);
    localparam logic [TIME_W-1:0]  INTERVAL_TOP  = {TIME_W{1'b1}};

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [TIME_W-1:0]   s_frame_time_us;
    logic                m_valid;
    logic                m_ready;
    logic [RATE_W-1:0]   m_current_rate;
    logic [RATE_W-1:0]   m_mean_rate;
    logic [RATE_W-1:0]   m_low_rate;
    logic [RATE_W-1:0]   m_high_rate;
    logic                m_report_fresh;

    int fail_count;
    int pending;

    // shared knobs between the request driver and the result sink:
    // idle_odds 0 means no idling at all, otherwise a random idle burst with odds of one in idle_odds
    int idle_odds = 0;
    bit hold_req  = 1'b0;

    frame_rate_window_stats_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_frame_time_us (s_frame_time_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_current_rate  (m_current_rate),
        .m_mean_rate     (m_mean_rate),
        .m_low_rate      (m_low_rate),
        .m_high_rate     (m_high_rate),
        .m_report_fresh  (m_report_fresh)
    );

    // watches both channels and the register port, predicts and compares
    frws_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_frame_time_us (s_frame_time_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_current_rate  (m_current_rate),
        .m_mean_rate     (m_mean_rate),
        .m_low_rate      (m_low_rate),
        .m_high_rate     (m_high_rate),
        .m_report_fresh  (m_report_fresh),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #RUN_LIMIT;
        $display("CHECK FAILED");
        $finish;
    end

    // result sink: random stall bursts, plus one long hold-off on request so
    // the block backs up and drops s_ready while requests keep coming
    initial begin
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // register write with a setup and an access phase; upper data bits are junk that must be dropped
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [TIME_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {(PDATA_W-TIME_W)'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // one frame request; called in step with the clock, returns once the
    // request has been taken
    task automatic send_frame(input logic [TIME_W-1:0] t);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_frame_time_us <= t;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // stop offering and wait until every predicted result has been taken
    task automatic wait_all_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
    endtask

    // mostly frame times around real display rates, with zero, very short
    // frames, long stalls and the full 24-bit range mixed in
    function automatic logic [TIME_W-1:0] pick_frame_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return '0;
        end else if (r < 10) begin
            return TIME_W'($urandom_range(1, 255));
        end else if (r < 22) begin
            return TIME_W'($urandom);
        end else if (r < 32) begin
            return TIME_W'($urandom_range(100000, 2000000));
        end else begin
            return TIME_W'($urandom_range(2000, 60000));
        end
    endfunction

    function automatic logic [TIME_W-1:0] pick_interval();
        case ($urandom_range(0, 2))
            0: return TIME_W'($urandom_range(1, INTERVAL_TOP));
            1: return TIME_W'($urandom_range(20000, 1000000));
            default: return TIME_W'($urandom_range(1, 5000));
        endcase
    endfunction

    // opener under the reset interval of 500000: saturating zero time, field
    // extremes, bit patterns, a huge frame that reports at once, zero right
    // after a report, and a run that lands exactly on the interval
    logic [TIME_W-1:0] opener [] = '{
        24'd0, 24'd1, 24'd2, 24'd255, 24'd256, 24'd16666, 24'd16667, 24'd33333,
        24'h555555, 24'hAAAAAA, 24'hFFFFFF, 24'd0, 24'd1000000, 24'd3,
        24'd499996, 24'd1, 24'h7FFFFF, 24'h800000
    };

    initial begin
        logic [TIME_W-1:0] interval;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        s_valid         <= 1'b0;
        s_frame_time_us <= '0;
        aresetn         <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_odds = 6;
        foreach (opener[i]) begin
            send_frame(opener[i]);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            // the block must be idle before its interval changes
            wait_all_results();
            case (ph)
                0: interval = TIME_W'(1);
                1: interval = INTERVAL_TOP;
                2: interval = '0;  // out of range: every request reports
                3: interval = INTERVAL_RESET;
                PHASES - 1: interval = INTERVAL_RESET;
                default: interval = pick_interval();
            endcase
            if (ph == 3) begin
                apb_write(SPARE_ADDR, TIME_W'($urandom));
            end
            apb_write(INTERVAL_ADDR, interval);

            // last phase runs flat out on both sides
            if (ph == PHASES - 1) begin
                idle_odds = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                idle_odds = 0;
            end else begin
                idle_odds = $urandom_range(3, 40);
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long sink hold-off early in one phase while requests keep flowing
                if (ph == 4 && n == 5) begin
                    hold_req = 1'b1;
                end
                send_frame(pick_frame_time());
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
